// ----- hdl/gdr_pkg.sv -----
package gdr_pkg;

    localparam int YEAR_W  = 16;
    localparam int COUNT_W = 16;

    localparam logic [3:0]        MONTH_RESET = 4'd1;
    localparam logic [4:0]        DAY_RESET   = 5'd1;
    localparam logic [YEAR_W-1:0] YEAR_RESET  = YEAR_W'(2000);

    // command codes on the input tuser
    localparam logic [1:0] CMD_SET     = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_COMPARE = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_SET_OK,
        OP_SET_BAD,
        OP_ADVANCE,
        OP_COMPARE,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } item_t;

    // stored date as seen by the top level
    typedef struct packed {
        logic [3:0]        month;
        logic [4:0]        day;
        logic [YEAR_W-1:0] year;
    } date_t;

    // 4/100/400 rule; divisibility by 25 via reciprocal multiply (exact for 16 bits)
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [32:0] prod;
        logic [11:0] q;
        logic [16:0] q25;
        logic        div25;
        prod  = {17'd0, y} * 33'd83887;
        q     = prod[32:21];
        q25   = {1'b0, q, 4'd0} + {2'b0, q, 3'd0} + {5'd0, q};
        div25 = (q25 == {1'b0, y});
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    // month length; zero for a month code outside 1..12
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [YEAR_W-1:0] y);
        logic [4:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:    n = is_leap(y) ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // days before the first of the month in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/gdr_front.sv -----
module gdr_front import gdr_pkg::*; (
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // month[3:0], day[8:4], year[24:9], day_count[40:25]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic        q_full,
    output logic        push,
    output item_t       push_item
);

    logic [3:0]         month;
    logic [4:0]         day;
    logic [YEAR_W-1:0]  year;
    logic [COUNT_W-1:0] count;
    logic [4:0]         dim;
    logic               set_ok;

    assign month = s_tdata[3:0];
    assign day   = s_tdata[8:4];
    assign year  = s_tdata[24:9];
    assign count = s_tdata[40:25];

    // take a word whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // set is checked here so the back end only loads
    assign dim    = days_in(month, year);
    assign set_ok = (dim != 5'd0) && (day != 5'd0) && (day <= dim);

    always_comb begin
        push_item.month = month;
        push_item.day   = day;
        push_item.year  = year;
        push_item.count = count;
        case (s_tuser)
            CMD_SET:     push_item.op = set_ok ? OP_SET_OK : OP_SET_BAD;
            CMD_ADVANCE: push_item.op = OP_ADVANCE;
            CMD_COMPARE: push_item.op = OP_COMPARE;
            default:     push_item.op = OP_NOP;
        endcase
    end

endmodule

// ----- hdl/gdr_queue.sv -----
module gdr_queue import gdr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  q_valid,
    output item_t q_item
);

    item_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full    = (fill_reg == 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = mem[rd_ptr_reg];

    // two-entry FIFO between classifier and executor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                mem[wr_ptr_reg] <= push_item;
                wr_ptr_reg      <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/gdr_exec.sv -----
module gdr_exec import gdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // accepted[0], order[2:1], month[6:3], day[11:7],
                                   // year[27:12], ordinal_day[36:28]
    output date_t       status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    localparam logic signed [1:0] ORD_LT = -2'sd1;
    localparam logic signed [1:0] ORD_EQ = 2'sd0;
    localparam logic signed [1:0] ORD_GT = 2'sd1;

    state_t             state_reg;
    logic [3:0]         month_reg;
    logic [4:0]         day_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               acc_reg;
    logic signed [1:0]  ord_reg;
    logic               out_valid_reg;
    logic               out_acc_reg;
    logic signed [1:0]  out_ord_reg;
    logic [3:0]         out_month_reg;
    logic [4:0]         out_day_reg;
    logic [YEAR_W-1:0]  out_year_reg;
    logic [8:0]         out_ordinal_reg;

    logic [4:0]         dim;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] step;
    logic [8:0]         ordinal;
    logic [24:0]        stored_key;
    logic [24:0]        given_key;
    logic               out_load;

    assign pop = (state_reg == ST_IDLE) && q_valid;

    // output register takes a finished result when empty or being drained
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // one month per cycle while advancing
    assign dim  = days_in(month_reg, year_reg);
    assign sum  = {{(COUNT_W-4){1'b0}}, day_reg} + {1'b0, count_reg};
    assign step = COUNT_W'(dim) - COUNT_W'(day_reg) + COUNT_W'(1);

    // day of year from the settled date
    assign ordinal = {4'd0, day_reg} + cum_days(month_reg)
                   + {8'd0, (month_reg > 4'd2) && is_leap(year_reg)};

    // year, month, day compare as one key
    assign stored_key = {year_reg, month_reg, day_reg};
    assign given_key  = {q_item.year, q_item.month, q_item.day};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            month_reg     <= MONTH_RESET;
            day_reg       <= DAY_RESET;
            year_reg      <= YEAR_RESET;
        end else begin
            if (out_valid_reg && m_tready && !out_load) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        count_reg <= q_item.count;
                        case (q_item.op)
                            OP_SET_OK: begin
                                month_reg <= q_item.month;
                                day_reg   <= q_item.day;
                                year_reg  <= q_item.year;
                                acc_reg   <= 1'b1;
                                ord_reg   <= ORD_EQ;
                                state_reg <= ST_DONE;
                            end
                            OP_ADVANCE: begin
                                acc_reg   <= 1'b0;
                                ord_reg   <= ORD_EQ;
                                state_reg <= ST_RUN;
                            end
                            OP_COMPARE: begin
                                acc_reg   <= 1'b0;
                                state_reg <= ST_DONE;
                                if (stored_key < given_key) begin
                                    ord_reg <= ORD_LT;
                                end else if (stored_key == given_key) begin
                                    ord_reg <= ORD_EQ;
                                end else begin
                                    ord_reg <= ORD_GT;
                                end
                            end
                            default: begin
                                acc_reg   <= 1'b0;
                                ord_reg   <= ORD_EQ;
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RUN: begin
                    if (sum <= {{(COUNT_W-4){1'b0}}, dim}) begin
                        day_reg   <= sum[4:0];
                        state_reg <= ST_DONE;
                    end else begin
                        count_reg <= count_reg - step;
                        day_reg   <= 5'd1;
                        if (month_reg >= 4'd12) begin
                            month_reg <= 4'd1;
                            year_reg  <= year_reg + YEAR_W'(1);
                        end else begin
                            month_reg <= month_reg + 4'd1;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        out_valid_reg   <= 1'b1;
                        out_acc_reg     <= acc_reg;
                        out_ord_reg     <= ord_reg;
                        out_month_reg   <= month_reg;
                        out_day_reg     <= day_reg;
                        out_year_reg    <= year_reg;
                        out_ordinal_reg <= ordinal;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_ordinal_reg, out_year_reg, out_day_reg, out_month_reg,
                       out_ord_reg, out_acc_reg};

    assign status.month = month_reg;
    assign status.day   = day_reg;
    assign status.year  = year_reg;

endmodule

// ----- hdl/gregorian_date_register.sv -----
// Gregorian date register. Holds one date (reset 1/1/2000) and returns one result word per
// command word: set (loads only a real date, 4/100/400 leap rule), advance by an unsigned day
// count, or compare against a given date. A front end classifies and validates commands into
// a two-entry queue; the executor works one command at a time. Set, compare and the unused
// code go from the queue through the executor's done state into the output register; advance
// first walks the date one month boundary at a time in the executor's month-stepping loop.
// The input side keeps accepting while the queue has room; a result waiting in the output
// register holds the executor in its final step, so the queue fills and then stalls the input.
// The year wraps at 65535.
module gregorian_date_register import gdr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // month_in[3:0], day_in[8:4], year_in[24:9],
                                   // day_count[40:25]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // accepted[0], order[2:1], cur_month[6:3], cur_day[11:7],
                                   // cur_year[27:12], ordinal_day[36:28]
);

    logic  push;
    item_t push_item;
    logic  q_full;
    logic  q_valid;
    item_t q_item;
    logic  pop;
    date_t status;

    gdr_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    gdr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    gdr_exec u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

    // stored date is always a real calendar date
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.month >= 4'd1) && (status.month <= 4'd12) && (status.day != 5'd0)
        && (status.day <= days_in(status.month, status.year)))
        else $error("stored date out of range");

    // a loaded set never carries a compare outcome
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[2:1] == 2'd0))
        else $error("accepted result with nonzero order");

    // ordinal day within 1..366
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[36:28] != 9'd0) && (m_tdata[36:28] <= 9'd366)))
        else $error("ordinal day out of range");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import gdr_pkg::*;

    // command code left unused by the block; it only reports the stored date
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // compare outcome as carried in the two-bit order field
    localparam logic [1:0] ORDER_EARLIER = 2'b11;
    localparam logic [1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [1:0] ORDER_LATER   = 2'b01;

    localparam int RANDOM_WORDS = 250;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_AFTER   = 50;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        logic              accepted;
        logic [1:0]        order;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [YEAR_W-1:0] year;
        logic [8:0]        yday;
    } date_result_t;

    // Calendar tracker: follows the stored date word by word and queues the
    // result word each accepted command word should produce.
    class date_tracker;
        logic [3:0]        cur_month;
        logic [4:0]        cur_day;
        logic [YEAR_W-1:0] cur_year;
        date_result_t      expected_q[$];
        int                mismatches;
        int                reported;

        function new();
            cur_month  = MONTH_RESET;
            cur_day    = DAY_RESET;
            cur_year   = YEAR_RESET;
            mismatches = 0;
            reported   = 0;
        endfunction

        function bit leap(input logic [YEAR_W-1:0] y);
            int unsigned v;
            v = 32'(y);
            return ((v % 4 == 0) && (v % 100 != 0)) || (v % 400 == 0);
        endfunction

        // zero for a month code outside 1..12
        function int unsigned month_len(input logic [3:0] m, input logic [YEAR_W-1:0] y);
            case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
                4'd4, 4'd6, 4'd9, 4'd11: return 30;
                4'd2: return leap(y) ? 29 : 28;
                default: return 0;
            endcase
        endfunction

        function int unsigned day_of_year();
            int unsigned total;
            int          i;
            total = 32'(cur_day);
            for (i = 1; i < cur_month; i++)
                total += month_len(4'(i), cur_year);
            return total;
        endfunction

        // roll whole months until the remainder fits in the current month
        function void add_days(input int unsigned count);
            int unsigned dim;
            while (count > 0) begin
                dim = month_len(cur_month, cur_year);
                if (cur_day + count <= dim) begin
                    cur_day = 5'(cur_day + count);
                    count   = 0;
                end else begin
                    count   = count - (dim - cur_day + 1);
                    cur_day = 5'd1;
                    if (cur_month == 4'd12) begin
                        cur_month = 4'd1;
                        cur_year  = cur_year + YEAR_W'(1);
                    end else begin
                        cur_month = cur_month + 4'd1;
                    end
                end
            end
        endfunction

        function void note_word(input logic [1:0] cmd, input logic [3:0] m,
                                input logic [4:0] d, input logic [YEAR_W-1:0] y,
                                input logic [COUNT_W-1:0] cnt);
            date_result_t r;
            r.accepted = 1'b0;
            r.order    = ORDER_EQUAL;
            case (cmd)
                CMD_SET: begin
                    if (month_len(m, y) != 0 && d != 0 && d <= month_len(m, y)) begin
                        cur_month  = m;
                        cur_day    = d;
                        cur_year   = y;
                        r.accepted = 1'b1;
                    end
                end
                CMD_ADVANCE: add_days(32'(cnt));
                CMD_COMPARE: begin
                    if ({cur_year, cur_month, cur_day} < {y, m, d})
                        r.order = ORDER_EARLIER;
                    else if ({cur_year, cur_month, cur_day} == {y, m, d})
                        r.order = ORDER_EQUAL;
                    else
                        r.order = ORDER_LATER;
                end
                default: ;
            endcase
            r.month = cur_month;
            r.day   = cur_day;
            r.year  = cur_year;
            r.yday  = 9'(day_of_year());
            expected_q.push_back(r);
        endfunction

        function void check_word(input logic [39:0] w);
            date_result_t got;
            date_result_t exp;
            got.accepted = w[0];
            got.order    = w[2:1];
            got.month    = w[6:3];
            got.day      = w[11:7];
            got.year     = w[27:12];
            got.yday     = w[36:28];
            if (expected_q.size() == 0) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected result word %h with nothing outstanding", w);
                end
                return;
            end
            exp = expected_q.pop_front();
            if (got.accepted !== exp.accepted || got.order !== exp.order ||
                got.month !== exp.month || got.day !== exp.day ||
                got.year !== exp.year || got.yday !== exp.yday) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch: expected acc=%0d ord=%b %0d/%0d/%0d yday=%0d",
                             exp.accepted, exp.order, exp.month, exp.day, exp.year,
                             exp.yday);
                    $display("          actual   acc=%0d ord=%b %0d/%0d/%0d yday=%0d",
                             got.accepted, got.order, got.month, got.day, got.year,
                             got.yday);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // month_in[3:0], day_in[8:4], year_in[24:9], day_count[40:25]
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // accepted[0], order[2:1], cur_month[6:3], cur_day[11:7],
                            // cur_year[27:12], ordinal_day[36:28]

    // tracker fed from the bus; plan is the sender's own copy for aiming compares
    date_tracker tracker = new();
    date_tracker plan    = new();
    int          burst_left;

    gregorian_date_register u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // bus monitor: note accepted command words, check accepted result words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tracker.note_word(s_tuser, s_tdata[3:0], s_tdata[8:4], s_tdata[24:9],
                                  s_tdata[40:25]);
            if (m_tvalid && m_tready)
                tracker.check_word(m_tdata);
        end
    end

    // offer one command word, opening a new burst with a random gap when due
    task automatic send_word(input logic [1:0] cmd, input logic [3:0] m, input logic [4:0] d,
                             input logic [YEAR_W-1:0] y, input logic [COUNT_W-1:0] cnt);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, cnt, y, d, m};
        do @(posedge aclk); while (!s_tready);
        plan.note_word(cmd, m, d, y, cnt);
    endtask

    function automatic logic [YEAR_W-1:0] pick_year();
        case ($urandom_range(0, 4))
            0: return YEAR_W'($urandom_range(0, 65535));
            1: return YEAR_W'($urandom_range(1890, 2110));
            2: return YEAR_W'($urandom_range(0, 163) * 400);
            3: return YEAR_W'($urandom_range(0, 655) * 100);
            default: return YEAR_W'($urandom_range(65525, 65535));
        endcase
    endfunction

    // mostly short hops, a few crossing many years
    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return COUNT_W'($urandom_range(0, 40));
        if (r < 85) return COUNT_W'($urandom_range(0, 400));
        if (r < 97) return COUNT_W'($urandom_range(0, 5000));
        return COUNT_W'($urandom_range(0, 65535));
    endfunction

    // result side: rotating stall modes plus one long hold-off
    initial begin : result_sink
        int cyc;
        int mode;
        int hold_left;
        int seen;
        bit held;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        seen      = 0;
        held      = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                seen++;
            cyc++;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (!held && seen >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) < 7);
                    2: m_tready <= (cyc % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int                 n;
        int                 sel;
        logic [1:0]         cmd;
        logic [3:0]         m;
        logic [4:0]         d;
        logic [YEAR_W-1:0]  y;
        logic [COUNT_W-1:0] cnt;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_SET;
        burst_left = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset date, leap rule, invalid sets, year wrap, field extremes
        send_word(CMD_UNUSED,  4'd0,  5'd0,  16'd0,     16'd0);
        send_word(CMD_COMPARE, 4'd1,  5'd1,  16'd2000,  16'd0);
        send_word(CMD_SET,     4'd2,  5'd29, 16'd2000,  16'd0);
        send_word(CMD_SET,     4'd2,  5'd29, 16'd1900,  16'd0);
        send_word(CMD_SET,     4'd2,  5'd29, 16'd2001,  16'd0);
        send_word(CMD_SET,     4'd2,  5'd29, 16'd2004,  16'd0);
        send_word(CMD_SET,     4'd0,  5'd1,  16'd2004,  16'd0);
        send_word(CMD_SET,     4'd13, 5'd1,  16'd2004,  16'd0);
        send_word(CMD_SET,     4'd15, 5'd31, 16'd65535, 16'd65535);
        send_word(CMD_SET,     4'd4,  5'd31, 16'd2004,  16'd0);
        send_word(CMD_SET,     4'd4,  5'd0,  16'd2004,  16'd0);
        send_word(CMD_SET,     4'd12, 5'd31, 16'd2004,  16'd0);
        send_word(CMD_ADVANCE, 4'd0,  5'd0,  16'd0,     16'd0);
        send_word(CMD_ADVANCE, 4'd0,  5'd0,  16'd0,     16'd1);
        send_word(CMD_SET,     4'd12, 5'd31, 16'd65535, 16'd0);
        send_word(CMD_ADVANCE, 4'd15, 5'd31, 16'd65535, 16'd1);
        send_word(CMD_COMPARE, 4'd0,  5'd0,  16'd0,     16'd0);
        send_word(CMD_SET,     4'd2,  5'd28, 16'd0,     16'd0);
        send_word(CMD_ADVANCE, 4'd0,  5'd0,  16'd0,     16'd1);
        send_word(CMD_ADVANCE, 4'd0,  5'd0,  16'd0,     16'd65535);
        send_word(CMD_COMPARE, 4'd15, 5'd31, 16'd65535, 16'd0);
        send_word(CMD_SET,     4'd12, 5'd31, 16'd2100,  16'd0);
        send_word(CMD_UNUSED,  4'd15, 5'd31, 16'd65535, 16'd65535);

        // random: mostly real dates, advances and compares aimed near the stored date
        for (n = 0; n < RANDOM_WORDS; n++) begin
            sel = $urandom_range(0, 99);
            m   = 4'($urandom_range(0, 15));
            d   = 5'($urandom_range(0, 31));
            y   = pick_year();
            cnt = COUNT_W'($urandom_range(0, 65535));
            if (sel < 30) begin
                cmd = CMD_SET;
                m   = 4'($urandom_range(1, 12));
                if ($urandom_range(0, 2) == 0)
                    d = 5'(plan.month_len(m, y));
                else
                    d = 5'($urandom_range(1, plan.month_len(m, y)));
            end else if (sel < 38) begin
                cmd = CMD_SET;
            end else if (sel < 65) begin
                cmd = CMD_ADVANCE;
                cnt = pick_count();
            end else if (sel < 95) begin
                cmd = CMD_COMPARE;
                m   = plan.cur_month;
                d   = plan.cur_day;
                y   = plan.cur_year;
                case ($urandom_range(0, 5))
                    0, 1: ;
                    2: d = $urandom_range(0, 1) ? d + 5'd1 : d - 5'd1;
                    3: m = $urandom_range(0, 1) ? m + 4'd1 : m - 4'd1;
                    4: y = $urandom_range(0, 1) ? y + YEAR_W'(1) : y - YEAR_W'(1);
                    default: begin
                        m = 4'($urandom_range(0, 15));
                        d = 5'($urandom_range(0, 31));
                        y = pick_year();
                    end
                endcase
            end else begin
                cmd = CMD_UNUSED;
            end
            send_word(cmd, m, d, y, cnt);
        end

        // drain: wait for every expected word, then a little longer for strays
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/gdr_pkg.sv
hdl/gdr_front.sv
hdl/gdr_queue.sv
hdl/gdr_exec.sv
hdl/gregorian_date_register.sv
bench/tb_top.sv
